// ===== rtl/fbmd_pkg.sv =====
// Shared types and constants for the fall, bump and motion detector.
// Used by the controller, the datapath and the top level.
package fbmd_pkg;

   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [REG_IDX_W-1:0] REG_SHOCK_THRESHOLD  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FALL_CONFIRM_MS  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BUMP_RECOVER_MS  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FALL_HOLD_MS     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MOTION_THRESHOLD = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LPF_ALPHA        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_THROTTLE_GAIN    = 3'd6;

   localparam logic [15:0] RST_SHOCK_THRESHOLD  = 16'd29491;
   localparam logic [15:0] RST_FALL_CONFIRM_MS  = 16'd1500;
   localparam logic [15:0] RST_BUMP_RECOVER_MS  = 16'd500;
   localparam logic [15:0] RST_FALL_HOLD_MS     = 16'd1000;
   localparam logic [14:0] RST_MOTION_THRESHOLD = 15'd819;
   localparam logic [15:0] RST_LPF_ALPHA        = 16'd9830;
   localparam logic [19:0] RST_THROTTLE_GAIN    = 20'd36408;

   localparam logic [12:0] FULL_THROTTLE = 13'd4096;

   typedef enum logic [1:0] {
      IMPACT_NORMAL = 2'd0,
      IMPACT_BUMP   = 2'd1,
      IMPACT_FALL   = 2'd2
   } impact_type;

   typedef enum logic [1:0] {
      MOTION_STEADY = 2'd0,
      MOTION_ACCEL  = 2'd1,
      MOTION_DECEL  = 2'd2
   } motion_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
      logic mot;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/fbmd_ctrl.sv =====
// Sequencer for the detector: accepts one transaction and steps the datapath.
// Depends on fbmd_pkg for the command and status structs.
module fbmd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fbmd_pkg::status_type sts,
   output fbmd_pkg::cmd_type   cmd
);
   import fbmd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_ACC  = 5'b00100,
      S_MOT  = 5'b01000,
      S_GAIN = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_MOT;
         end
         S_MOT: begin
            cmd.mot  = 1'b1;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded while output register busy");
   a_load_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.mul)
      else $error("multiply step did not follow accept");
   a_mul_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.acc)
      else $error("accumulate step did not follow multiply");
   a_acc_mot: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |=> cmd.mot)
      else $error("motion step did not follow accumulate");

endmodule

// ===== rtl/fbmd_dp.sv =====
// Datapath: config registers, filter, impact tracker, fall hold, throttle.
// Depends on fbmd_pkg; driven by commands from fbmd_ctrl.
module fbmd_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  fbmd_pkg::cmd_type                 cmd,
   output fbmd_pkg::status_type              sts,
   input  logic                              csr_write_en,
   input  logic [fbmd_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [fbmd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic signed [15:0]                req_accel_x,
   input  logic signed [15:0]                req_accel_y,
   input  logic signed [15:0]                req_accel_z,
   input  logic [31:0]                       req_time_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_impact_event,
   output logic [1:0]                        rsp_motion_state,
   output logic [12:0]                       rsp_throttle,
   output logic                              rsp_fall_hold,
   output logic signed [15:0]                rsp_filtered_accel
);
   import fbmd_pkg::*;

   logic [15:0] shock_thr_ff, confirm_ff, recover_ff, hold_ms_ff, alpha_ff;
   logic [14:0] motion_thr_ff;
   logic [19:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shock_thr_ff  <= RST_SHOCK_THRESHOLD;
         confirm_ff    <= RST_FALL_CONFIRM_MS;
         recover_ff    <= RST_BUMP_RECOVER_MS;
         hold_ms_ff    <= RST_FALL_HOLD_MS;
         motion_thr_ff <= RST_MOTION_THRESHOLD;
         alpha_ff      <= RST_LPF_ALPHA;
         gain_ff       <= RST_THROTTLE_GAIN;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_SHOCK_THRESHOLD:  shock_thr_ff  <= csr_wdata[15:0];
            REG_FALL_CONFIRM_MS:  confirm_ff    <= csr_wdata[15:0];
            REG_BUMP_RECOVER_MS:  recover_ff    <= csr_wdata[15:0];
            REG_FALL_HOLD_MS:     hold_ms_ff    <= csr_wdata[15:0];
            REG_MOTION_THRESHOLD: motion_thr_ff <= csr_wdata[14:0];
            REG_LPF_ALPHA:        alpha_ff      <= csr_wdata[15:0];
            REG_THROTTLE_GAIN:    gain_ff       <= csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   // sample capture
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [31:0]        now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff  <= req_accel_x;
         ay_ff  <= req_accel_y;
         az_ff  <= req_accel_z;
         now_ff <= req_time_ms;
      end
   end

   // multiply step
   logic signed [31:0] lpf_ff, lpf_in;
   logic signed [32:0] diff;
   logic signed [49:0] step_prod, step_ff;
   logic signed [31:0] sqx_full, sqy_full, sqz_full;
   logic [31:0]        lim_full;
   logic [30:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [31:0]        lim_ff;

   assign diff      = $signed({ax_ff[15], ax_ff, 16'd0}) - $signed({lpf_ff[31], lpf_ff});
   assign step_prod = 50'($signed({1'b0, alpha_ff})) * 50'(diff);
   assign sqx_full  = 32'(ax_ff) * 32'(ax_ff);
   assign sqy_full  = 32'(ay_ff) * 32'(ay_ff);
   assign sqz_full  = 32'(az_ff) * 32'(az_ff);
   assign lim_full  = 32'(shock_thr_ff) * 32'(shock_thr_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         step_ff <= step_prod;
         sqx_ff  <= sqx_full[30:0];
         sqy_ff  <= sqy_full[30:0];
         sqz_ff  <= sqz_full[30:0];
         lim_ff  <= lim_full;
      end
   end

   // accumulate step: filter update and impact tracker
   logic        track_ff, track_in;
   logic [31:0] start_ff, start_in;
   logic        hold_ff, hold_in;
   logic [31:0] fall_time_ff, fall_time_in;
   impact_type  event_ff, event_in;

   logic [32:0] mag2;
   logic [31:0] yz;
   logic [33:0] yz3;
   logic [32:0] z3;
   logic        az_pos, roll_big, pitch_big, tilt, shock;
   logic [31:0] elapsed, since_fall;

   assign lpf_in    = lpf_ff + step_ff[47:16];
   assign mag2      = {2'b0, sqx_ff} + {2'b0, sqy_ff} + {2'b0, sqz_ff};
   assign shock     = mag2 > {1'b0, lim_ff};
   assign yz        = {1'b0, sqy_ff} + {1'b0, sqz_ff};
   assign yz3       = {1'b0, yz, 1'b0} + {2'b0, yz};
   assign pitch_big = {3'b0, sqx_ff} > yz3;
   assign z3        = {1'b0, sqz_ff, 1'b0} + {2'b0, sqz_ff};
   assign az_pos    = !az_ff[15] && (az_ff != 16'sd0);
   assign roll_big  = az_pos ? ({2'b0, sqy_ff} > z3)
                             : ((ay_ff != 16'sd0) || (az_ff != 16'sd0));
   assign tilt      = roll_big || pitch_big;
   assign elapsed   = now_ff - start_ff;

   always_comb begin
      track_in     = track_ff;
      start_in     = start_ff;
      event_in     = IMPACT_NORMAL;
      hold_in      = hold_ff;
      fall_time_in = fall_time_ff;
      if (!track_ff) begin
         if (shock) begin
            track_in = 1'b1;
            start_in = now_ff;
         end
      end else if (tilt && (elapsed > {16'd0, confirm_ff})) begin
         track_in = 1'b0;
         event_in = IMPACT_FALL;
      end else if (!tilt && (elapsed > {16'd0, recover_ff})) begin
         track_in = 1'b0;
         event_in = IMPACT_BUMP;
      end
      if (event_in == IMPACT_FALL) begin
         hold_in      = 1'b1;
         fall_time_in = now_ff;
      end else if (hold_ff && (since_fall > {16'd0, hold_ms_ff})) begin
         hold_in = 1'b0;
      end
   end

   assign since_fall = now_ff - fall_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lpf_ff       <= '0;
         track_ff     <= 1'b0;
         start_ff     <= '0;
         hold_ff      <= 1'b0;
         fall_time_ff <= '0;
      end else if (cmd.acc) begin
         lpf_ff       <= lpf_in;
         track_ff     <= track_in;
         start_ff     <= start_in;
         hold_ff      <= hold_in;
         fall_time_ff <= fall_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         event_ff <= event_in;
      end
   end

   // motion step
   logic signed [32:0] lpf_ext, thr_q16, neg_thr, excess;
   logic               accel, decel;
   motion_type         motion_ff, motion_in;
   logic [30:0]        excess_ff;

   assign lpf_ext = {lpf_ff[31], lpf_ff};
   assign thr_q16 = $signed({2'b0, motion_thr_ff, 16'd0});
   assign neg_thr = 33'sd0 - thr_q16;
   assign accel   = lpf_ext > thr_q16;
   assign decel   = lpf_ext < neg_thr;
   assign excess  = lpf_ext - thr_q16;

   always_comb begin
      if (accel) begin
         motion_in = MOTION_ACCEL;
      end else if (decel) begin
         motion_in = MOTION_DECEL;
      end else begin
         motion_in = MOTION_STEADY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mot) begin
         motion_ff <= motion_in;
         excess_ff <= accel ? excess[30:0] : 31'd0;
      end
   end

   // throttle step and result register
   logic [50:0] gain_prod;
   logic [18:0] thr_raw;
   logic [12:0] throttle_in;

   assign gain_prod   = 51'(excess_ff) * 51'(gain_ff);
   assign thr_raw     = gain_prod[50:32];
   assign throttle_in = (thr_raw > {6'd0, FULL_THROTTLE}) ? FULL_THROTTLE : thr_raw[12:0];

   logic              rsp_valid_ff, rsp_valid_in;
   impact_type        rsp_event_ff;
   motion_type        rsp_motion_ff;
   logic [12:0]       rsp_throttle_ff;
   logic              rsp_hold_ff;
   logic signed [15:0] rsp_filt_ff;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_event_ff    <= event_ff;
         rsp_motion_ff   <= motion_ff;
         rsp_throttle_ff <= throttle_in;
         rsp_hold_ff     <= hold_ff;
         rsp_filt_ff     <= lpf_ff[31:16];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_impact_event   = rsp_event_ff;
   assign rsp_motion_state   = rsp_motion_ff;
   assign rsp_throttle       = rsp_throttle_ff;
   assign rsp_fall_hold      = rsp_hold_ff;
   assign rsp_filtered_accel = rsp_filt_ff;

endmodule

// ===== rtl/imu_fall_bump_motion_detector.sv =====
// Top level of the accelerometer fall, bump and motion detector.
// Instantiates fbmd_ctrl and fbmd_dp; depends on fbmd_pkg.
//
// One sample (x, y, z at 16384 LSB per g plus a millisecond timestamp) is
// taken per transaction and yields exactly one result. The controller walks
// each sample through four datapath steps after acceptance: squares and the
// filter multiply, filter update with the shock and tilt tests, motion
// classification, then the throttle multiply that loads the output register.
// A new sample is accepted only after the previous one has loaded its result;
// a stalled result holds the sequence in its last step. Registers are written
// through csr_write_en, csr_index and csr_wdata, by the user only while no sample
// is in flight (the block does not enforce this); indexes past the list are ignored.
module imu_fall_bump_motion_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [fbmd_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [fbmd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [15:0]              req_accel_x,
   input  logic signed [15:0]              req_accel_y,
   input  logic signed [15:0]              req_accel_z,
   input  logic [31:0]                     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_impact_event,
   output logic [1:0]                      rsp_motion_state,
   output logic [12:0]                     rsp_throttle,
   output logic                            rsp_fall_hold,
   output logic signed [15:0]              rsp_filtered_accel
);
   import fbmd_pkg::*;

   cmd_type    cmd;
   status_type sts;

   fbmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbmd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .req_time_ms        (req_time_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_impact_event   (rsp_impact_event),
      .rsp_motion_state   (rsp_motion_state),
      .rsp_throttle       (rsp_throttle),
      .rsp_fall_hold      (rsp_fall_hold),
      .rsp_filtered_accel (rsp_filtered_accel)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for imu_fall_bump_motion_detector: directed and random samples
// over several register settings, each report checked against an in-bench model.
// Depends on fbmd_pkg and the detector RTL.
module tb;
   import fbmd_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 250;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic [31:0]        stamp;
   } sample_type;

   typedef struct {
      impact_type         impact;
      motion_type         motion;
      logic [12:0]        throttle;
      logic               hold;
      logic signed [15:0] filt;
   } report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [REG_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_accel_x = '0;
   logic signed [15:0]    req_accel_y = '0;
   logic signed [15:0]    req_accel_z = '0;
   logic [31:0]           req_time_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_impact_event;
   logic [1:0]            rsp_motion_state;
   logic [12:0]           rsp_throttle;
   logic                  rsp_fall_hold;
   logic signed [15:0]    rsp_filtered_accel;

   imu_fall_bump_motion_detector i_dut (.*);

   // detector model: register copies and state
   logic [15:0] r_shock, r_confirm, r_recover, r_hold, r_alpha;
   logic [14:0] r_motion;
   logic [19:0] r_gain;
   logic        tracking, hold_flag;
   logic [31:0] shock_t0, fall_t;
   int          lpf_q16;

   sample_type  pending_samples[$];
   report_type  awaited_reports[$];
   logic        req_fire = 1'b0;
   bit          no_idle = 1'b0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          item_total = 0;
   int          rsp_count = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   logic [31:0] now_ms = '0;
   int          s_shock, s_confirm, s_recover;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic report_type next_report(sample_type s);
      report_type          r;
      longint              x, y, z, thr, excess;
      longint unsigned     scaled;
      logic [31:0]         elapsed, since_fall;
      logic                roll_big, pitch_big, tilt;
      x = s.ax;
      y = s.ay;
      z = s.az;
      r.impact = IMPACT_NORMAL;
      r.motion = MOTION_STEADY;
      r.throttle = '0;
      lpf_q16 = int'(lpf_q16 + ((longint'(r_alpha) * (x * 65536 - lpf_q16)) >>> 16));
      thr = longint'(r_motion) * 65536;
      if (lpf_q16 > thr) begin
         r.motion = MOTION_ACCEL;
         excess = lpf_q16 - thr;
         scaled = ($unsigned(excess) * r_gain) >> 32;
         r.throttle = (scaled > FULL_THROTTLE) ? FULL_THROTTLE : scaled[12:0];
      end else if (lpf_q16 < -thr) begin
         r.motion = MOTION_DECEL;
      end
      if (!tracking) begin
         if (x * x + y * y + z * z > longint'(r_shock) * r_shock) begin
            tracking = 1'b1;
            shock_t0 = s.stamp;
         end
      end else begin
         elapsed = s.stamp - shock_t0;
         if (z > 0) begin
            roll_big = y * y > 3 * z * z;
         end else begin
            roll_big = (y != 0) || (z != 0);
         end
         pitch_big = x * x > 3 * (y * y + z * z);
         tilt = roll_big || pitch_big;
         if (tilt && elapsed > r_confirm) begin
            tracking = 1'b0;
            r.impact = IMPACT_FALL;
         end else if (!tilt && elapsed > r_recover) begin
            tracking = 1'b0;
            r.impact = IMPACT_BUMP;
         end
      end
      if (r.impact == IMPACT_FALL) begin
         hold_flag = 1'b1;
         fall_t = s.stamp;
      end
      since_fall = s.stamp - fall_t;
      if (hold_flag && since_fall > r_hold) begin
         hold_flag = 1'b0;
      end
      r.hold = hold_flag;
      r.filt = 16'(lpf_q16 >>> 16);
      return r;
   endfunction

   // sample request driver
   always @(negedge clock) begin : req_driver
      sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            s = pending_samples.pop_front();
            req_accel_x <= s.ax;
            req_accel_y <= s.ay;
            req_accel_z <= s.az;
            req_time_ms <= s.stamp;
            req_valid <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 4);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // track registers, predict accepted samples, check reports
   always @(posedge clock) begin : monitor
      sample_type s;
      report_type want;
      if (reset) begin
         r_shock = RST_SHOCK_THRESHOLD;
         r_confirm = RST_FALL_CONFIRM_MS;
         r_recover = RST_BUMP_RECOVER_MS;
         r_hold = RST_FALL_HOLD_MS;
         r_motion = RST_MOTION_THRESHOLD;
         r_alpha = RST_LPF_ALPHA;
         r_gain = RST_THROTTLE_GAIN;
         tracking = 1'b0;
         shock_t0 = '0;
         lpf_q16 = 0;
         hold_flag = 1'b0;
         fall_t = '0;
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (csr_write_en) begin
            case (csr_index)
               REG_SHOCK_THRESHOLD:  r_shock = csr_wdata[15:0];
               REG_FALL_CONFIRM_MS:  r_confirm = csr_wdata[15:0];
               REG_BUMP_RECOVER_MS:  r_recover = csr_wdata[15:0];
               REG_FALL_HOLD_MS:     r_hold = csr_wdata[15:0];
               REG_MOTION_THRESHOLD: r_motion = csr_wdata[14:0];
               REG_LPF_ALPHA:        r_alpha = csr_wdata[15:0];
               REG_THROTTLE_GAIN:    r_gain = csr_wdata[19:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            s.ax = req_accel_x;
            s.ay = req_accel_y;
            s.az = req_accel_z;
            s.stamp = req_time_ms;
            awaited_reports.push_back(next_report(s));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (awaited_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected report at cycle %0d", cycle_count);
               end
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_impact_event !== want.impact || rsp_motion_state !== want.motion ||
                   rsp_throttle !== want.throttle || rsp_fall_hold !== want.hold ||
                   rsp_filtered_accel !== want.filt) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("report %0d mismatch (expected/actual): impact %0d/%0d",
                              rsp_count, want.impact, rsp_impact_event,
                              " motion %0d/%0d throttle %0d/%0d", want.motion,
                              rsp_motion_state, want.throttle, rsp_throttle,
                              " hold %0d/%0d filtered %0d/%0d", want.hold, rsp_fall_hold,
                              want.filt, rsp_filtered_accel);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int flip(int v);
      return $urandom_range(0, 1) ? v : -v;
   endfunction

   function automatic int rand_axis();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         default: return int'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic add_sample(int x, int y, int z, logic [31:0] t);
      sample_type s;
      s.ax = 16'(x);
      s.ay = 16'(y);
      s.az = 16'(z);
      s.stamp = t;
      pending_samples.push_back(s);
      item_total++;
   endtask

   task automatic add_posture(int pose, logic [31:0] t);
      case (pose)
         0: add_sample(flip($urandom_range(0, 3000)), flip($urandom_range(0, 3000)),
                       16384 + flip($urandom_range(0, 3000)), t);
         1: add_sample(flip($urandom_range(0, 8000)), flip($urandom_range(0, 16000)),
                       -int'($urandom_range(0, 16384)), t);
         2: add_sample(flip($urandom_range(0, 3000)), flip($urandom_range(12000, 24000)),
                       $urandom_range(0, 4000), t);
         default: add_sample(flip($urandom_range(16000, 32767)),
                             flip($urandom_range(0, 4000)), flip($urandom_range(0, 4000)), t);
      endcase
   endtask

   task automatic shock_episode();
      int          pose, lim;
      logic [31:0] t0;
      lim = (s_confirm > s_recover ? s_confirm : s_recover) / 3 + 20;
      now_ms += $urandom_range(0, 40);
      if (s_shock < 32767 && $urandom_range(0, 7) == 0) begin
         add_sample(flip(s_shock + $urandom_range(0, 1)), 0, 0, now_ms);
      end else begin
         add_sample(flip($urandom_range(20000, 32767)), flip($urandom_range(20000, 32767)),
                    flip($urandom_range(20000, 32767)), now_ms);
      end
      t0 = now_ms;
      pose = $urandom_range(0, 3);
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 3) == 0) begin
            pose = $urandom_range(0, 3);
         end
         case ($urandom_range(0, 9))
            0: now_ms = t0 + s_confirm + $urandom_range(0, 1);
            1: now_ms = t0 + s_recover + $urandom_range(0, 1);
            default: now_ms += $urandom_range(0, lim);
         endcase
         add_posture(pose, now_ms);
      end
   endtask

   task automatic drive_run();
      int base, x;
      base = flip($urandom_range(0, 32767));
      repeat ($urandom_range(4, 16)) begin
         x = base + flip($urandom_range(0, 1500));
         if (x > 32767) x = 32767;
         if (x < -32768) x = -32768;
         now_ms += $urandom_range(10, 30);
         add_sample(x, flip($urandom_range(0, 2000)), 16384 + flip($urandom_range(0, 2000)),
                    now_ms);
      end
   endtask

   task automatic add_noise();
      case ($urandom_range(0, 3))
         0: now_ms = $urandom();
         1: now_ms -= $urandom_range(1, 2000);
         default: now_ms += $urandom_range(0, 100);
      endcase
      add_sample(rand_axis(), rand_axis(), rand_axis(), now_ms);
   endtask

   task automatic run_phase(int n);
      int stop;
      stop = item_total + n;
      while (item_total < stop) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3: shock_episode();
            4, 5:       drive_run();
            default:    add_noise();
         endcase
      end
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(int shock, int confirm, int recover, int hold, int motion,
                            int alpha, int gain);
      write_reg(REG_SHOCK_THRESHOLD, shock);
      write_reg(REG_FALL_CONFIRM_MS, confirm);
      write_reg(REG_BUMP_RECOVER_MS, recover);
      write_reg(REG_FALL_HOLD_MS, hold);
      write_reg(REG_MOTION_THRESHOLD, motion);
      write_reg(REG_LPF_ALPHA, alpha);
      write_reg(REG_THROTTLE_GAIN, gain);
      s_shock = shock;
      s_confirm = confirm;
      s_recover = recover;
   endtask

   task automatic settle();
      wait (rsp_count == item_total);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int k;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: bump, fall, hold, thresholds, wrap and time going back
      add_sample(0, 0, 0, 0);
      add_sample(32767, 32767, 32767, 10);
      add_sample(0, 0, 16384, 30);
      add_sample(0, 0, 16384, 510);
      add_sample(0, 0, 16384, 511);
      add_sample(-32768, -32768, -32768, 600);
      add_sample(0, 16384, 0, 2100);
      add_sample(0, 16384, 0, 2101);
      add_sample(0, 0, -16384, 3101);
      add_sample(0, 0, 16384, 3102);
      add_sample(32767, 0, 0, 3200);
      add_sample(16384, 0, 0, 4701);
      add_sample(0, 0, 0, 4702);
      add_sample(29491, 0, 0, 4800);
      add_sample(29492, 0, 0, 4820);
      add_sample(0, 0, 0, 5400);
      add_sample(0, -32768, 32767, 5500);
      add_sample(0, 0, 16384, 5400);
      add_sample(-32768, 0, 0, 32'hFFFF_FF00);
      add_sample(0, 16384, 16384, 32'h0000_05F0);
      add_sample(0, 32767, -32768, 32'h0000_0700);
      add_sample(0, 0, -1, 32'h0000_0CDD);
      add_sample(0, 0, 16384, 32'h0000_10C6);
      settle();

      configure(0, 0, 0, 0, 0, 1, 0);
      now_ms = $urandom();
      run_phase(PHASE_ITEMS);
      settle();

      configure(65535, 65535, 65535, 65535, 32767, 65535, 1048575);
      run_phase(PHASE_ITEMS);
      settle();

      // frozen filter, ignored index, dropped upper bits
      configure($urandom_range(4000, 30000), $urandom_range(0, 800), $urandom_range(0, 600),
                $urandom_range(0, 1500), $urandom_range(0, 6000), 0, $urandom_range(0, 1048575));
      write_reg(REG_UNUSED, $urandom_range(0, 1048575));
      write_reg(REG_MOTION_THRESHOLD, 20'hF8000 | $urandom_range(0, 4000));
      k = $urandom_range(4000, 30000);
      write_reg(REG_SHOCK_THRESHOLD, 20'hF0000 | k);
      s_shock = k;
      now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      run_phase(PHASE_ITEMS);
      settle();

      for (k = 0; k < 4; k++) begin
         configure($urandom_range(4000, 30000), $urandom_range(0, 800),
                   $urandom_range(0, 600), $urandom_range(0, 1500), $urandom_range(0, 6000),
                   $urandom_range(1, 65535),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                             : $urandom_range(20000, 80000));
         if (k == 3) begin
            no_idle = 1'b1;
         end
         now_ms = $urandom();
         run_phase(PHASE_ITEMS);
         settle();
      end

      if (fail_count == 0 && awaited_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
